// ===== rtl/rtp_pkg.sv =====
package rtp_pkg;

  // Default build parameters
  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  // Fixed field widths
  localparam int LEN_W      = 7;
  localparam int LIMIT_W    = 10;
  localparam int LEVEL_W    = 14;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int SUM_W      = 38;
  localparam int POS_W      = 11;
  localparam int MONEY_W    = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERSOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERBOUGHT = 3'd3;

  // Register reset values
  localparam logic [LEN_W-1:0]   LEN_RST        = 7'd14;
  localparam logic [LIMIT_W-1:0] LIMIT_RST      = 10'd5;
  localparam logic [LEVEL_W-1:0] OVERSOLD_RST   = 14'd3000;
  localparam logic [LEVEL_W-1:0] OVERBOUGHT_RST = 14'd7000;

  // Index scale: 100 percent in hundredths of a percent
  localparam logic [LEVEL_W-1:0] SCALE_FACTOR = 14'd10000;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  // Warm-up status of the difference ring for the word at the input
  typedef struct packed {
    logic has_diff;
    logic ready;
  } ring_stat_t;

endpackage

// ===== rtl/rtp_if.sv =====
interface rtp_in_if #(
  parameter int PRICE_BITS = rtp_pkg::PRICE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface rtp_out_if;
  import rtp_pkg::*;

  logic                      valid;
  logic                      ready;
  action_t                   action;
  logic                      window_ready;
  logic [SUM_W-1:0]          gain_total;
  logic [SUM_W-1:0]          loss_total;
  logic signed [POS_W-1:0]   position;
  logic signed [MONEY_W-1:0] cash_flow;
  logic signed [MONEY_W-1:0] marked_value;

  modport source (
    output valid, output action, output window_ready, output gain_total,
    output loss_total, output position, output cash_flow, output marked_value,
    input ready
  );
  modport sink (
    input valid, input action, input window_ready, input gain_total,
    input loss_total, input position, input cash_flow, input marked_value,
    output ready
  );
endinterface

// ===== rtl/rtp_ring.sv =====
module rtp_ring #(
  parameter int MAX_WINDOW = rtp_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = rtp_pkg::PRICE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                advance,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     eff_len,
  input  logic signed [PRICE_BITS:0]          diff,
  output rtp_pkg::ring_stat_t                 stat,
  output logic signed [PRICE_BITS:0]          old_r
);
  import rtp_pkg::*;

  localparam int PTR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_EFF_W = $clog2(MAX_WINDOW+1);
  localparam int SEEN_W    = $clog2(MAX_WINDOW+2);
  localparam int ADDR_W    = LEN_EFF_W + 1;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_WINDOW - 1);
  localparam logic [ADDR_W-1:0] DEPTH    = ADDR_W'(MAX_WINDOW);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_WINDOW + 1);

  logic signed [PRICE_BITS:0] ring_mem [MAX_WINDOW];
  logic [PTR_W-1:0]           ptr_r;
  logic [PTR_W-1:0]           ptr_nxt;
  logic [SEEN_W-1:0]          seen_r;
  logic [ADDR_W-1:0]          leave_sum;
  logic [ADDR_W-1:0]          leave_wrap;
  logic [PTR_W-1:0]           leave_addr;

  // Locate the difference that drops out of the window
  always_comb begin
    leave_sum  = ADDR_W'(ptr_r) + DEPTH - ADDR_W'(eff_len);
    leave_wrap = (leave_sum >= DEPTH) ? (leave_sum - DEPTH) : leave_sum;
    leave_addr = leave_wrap[PTR_W-1:0];
    ptr_nxt    = (ptr_r == PTR_LAST) ? '0 : (ptr_r + PTR_W'(1));
  end

  // Fill count: an entry is read only once it was written since the restart
  assign stat.has_diff = (seen_r != '0);
  assign stat.ready    = (seen_r >= (SEEN_W'(eff_len) + SEEN_W'(1)));

  // Advance pointer and warm-up count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      seen_r <= '0;
    end else if (restart) begin
      ptr_r  <= '0;
      seen_r <= '0;
    end else if (advance) begin
      if (stat.has_diff) begin
        ptr_r <= ptr_nxt;
      end
      if (seen_r != SEEN_MAX) begin
        seen_r <= seen_r + SEEN_W'(1);
      end
    end
  end

  // Read the leaving entry before this word's write lands
  always_ff @(posedge clk) begin
    if (advance) begin
      old_r <= ring_mem[leave_addr];
      if (stat.has_diff) begin
        ring_mem[ptr_r] <= diff;
      end
    end
  end

endmodule

// ===== rtl/rsi_threshold_trader_core.sv =====
// Seven register stages, A to G, lie between input accept and output valid.
// Throughput: one word per cycle while the output is not stalled; the difference ring takes
// one read and at most one write per word, and the window sums and the position update per word.
// Reset: synchronous, active low; clears stage valids, sums, position and cash, loads config defaults.
// The ring needs no clearing pass: a fill count masks entries not yet written.
module rsi_threshold_trader_core #(
  parameter int MAX_WINDOW = rtp_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = rtp_pkg::PRICE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rtp_in_if.sink                         in_chan,
  rtp_out_if.source                      out_chan,
  input  logic                           cfg_wr_en,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtp_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import rtp_pkg::*;

  localparam int LEN_EFF_W = $clog2(MAX_WINDOW+1);
  localparam int CMP_W     = (LEN_W > LEN_EFF_W) ? LEN_W : LEN_EFF_W;
  localparam int ISUM_W    = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_S_W  = LEVEL_W + ISUM_W + 1;
  localparam int PROD_W    = POS_W + PRICE_BITS + 1;
  localparam int MSUM_W    = ((PROD_W > MONEY_W) ? PROD_W : MONEY_W) + 1;

  localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);

  // Clamp a wide signed sum into the money range
  function automatic logic signed [MONEY_W-1:0] sat_money(
    input logic signed [MSUM_W-1:0] v
  );
    logic [MSUM_W-MONEY_W:0] upper;
    upper = v[MSUM_W-1:MONEY_W-1];
    if (upper == '0 || upper == '1) begin
      return v[MONEY_W-1:0];
    end else if (v[MSUM_W-1]) begin
      return {1'b1, {(MONEY_W-1){1'b0}}};
    end else begin
      return {1'b0, {(MONEY_W-1){1'b1}}};
    end
  endfunction

  // Magnitude of a price difference
  function automatic logic [PRICE_BITS-1:0] diff_mag(input logic signed [PRICE_BITS:0] v);
    logic signed [PRICE_BITS:0] n;
    n = -v;
    return v[PRICE_BITS] ? n[PRICE_BITS-1:0] : v[PRICE_BITS-1:0];
  endfunction

  // Configuration registers
  logic [LEN_W-1:0]   window_len_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [LEVEL_W-1:0] oversold_r;
  logic [LEVEL_W-1:0] overbought_r;
  logic               restart;

  assign restart = cfg_wr_en && (cfg_index == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= LEN_RST;
      limit_r      <= LIMIT_RST;
      oversold_r   <= OVERSOLD_RST;
      overbought_r <= OVERBOUGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: window_len_r <= cfg_wr_data[LEN_W-1:0];
        REG_POS_LIMIT:  limit_r      <= cfg_wr_data[LIMIT_W-1:0];
        REG_OVERSOLD:   oversold_r   <= cfg_wr_data[LEVEL_W-1:0];
        REG_OVERBOUGHT: overbought_r <= cfg_wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window length into 1..MAX_WINDOW
  logic [CMP_W-1:0]     len_ext;
  logic [LEN_EFF_W-1:0] eff_len;

  always_comb begin
    len_ext = CMP_W'(window_len_r);
    if (len_ext == '0) begin
      eff_len = LEN_EFF_W'(1);
    end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = LEN_EFF_W'(MAX_WINDOW);
    end else begin
      eff_len = len_ext[LEN_EFF_W-1:0];
    end
  end

  // Stage occupancy and flow control
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v;
  logic space_a, space_b, space_c, space_d, space_e, space_f, space_g;
  logic accept;

  assign space_g = !g_v || out_chan.ready;
  assign space_f = !f_v || space_g;
  assign space_e = !e_v || space_f;
  assign space_d = !d_v || space_e;
  assign space_c = !c_v || space_d;
  assign space_b = !b_v || space_c;
  assign space_a = !a_v || space_b;

  assign in_chan.ready = space_a;
  assign accept        = in_chan.valid && space_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else begin
      if (space_a) a_v <= in_chan.valid;
      if (space_b) b_v <= a_v;
      if (space_c) c_v <= b_v;
      if (space_d) d_v <= c_v;
      if (space_e) e_v <= d_v;
      if (space_f) f_v <= e_v;
      if (space_g) g_v <= f_v;
    end
  end

  // Stage A: take the price, form the difference, touch the ring
  logic [PRICE_BITS-1:0]      in_price;
  logic [PRICE_BITS-1:0]      prev_price_r;
  logic signed [PRICE_BITS:0] in_diff;
  ring_stat_t                 ring_stat;
  logic signed [PRICE_BITS:0] old_rd;

  assign in_price = in_chan.price;
  assign in_diff  = signed'({1'b0, in_price}) - signed'({1'b0, prev_price_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_price_r <= '0;
    end else if (accept) begin
      prev_price_r <= in_price;
    end
  end

  rtp_ring #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .advance (accept),
    .eff_len (eff_len),
    .diff    (in_diff),
    .stat    (ring_stat),
    .old_r   (old_rd)
  );

  logic [PRICE_BITS-1:0]      a_price_r;
  logic signed [PRICE_BITS:0] a_diff_r;
  logic                       a_has_diff_r;
  logic                       a_ready_r;

  always_ff @(posedge clk) begin
    if (space_a) begin
      a_price_r    <= in_price;
      a_diff_r     <= in_diff;
      a_has_diff_r <= ring_stat.has_diff;
      a_ready_r    <= ring_stat.ready;
    end
  end

  // Stage B: update window sums
  logic [ISUM_W-1:0]          gain_sum_r;
  logic [ISUM_W-1:0]          loss_sum_r;
  logic [ISUM_W-1:0]          gain_sum_nxt;
  logic [ISUM_W-1:0]          loss_sum_nxt;
  logic signed [PRICE_BITS:0] old_eff;
  logic [PRICE_BITS-1:0]      b_price_r;
  logic                       b_ready_r;

  always_comb begin
    old_eff      = a_ready_r ? old_rd : '0;
    gain_sum_nxt = gain_sum_r;
    loss_sum_nxt = loss_sum_r;
    if (a_has_diff_r) begin
      if (old_eff > 0) begin
        gain_sum_nxt = gain_sum_nxt - ISUM_W'(diff_mag(old_eff));
      end else begin
        loss_sum_nxt = loss_sum_nxt - ISUM_W'(diff_mag(old_eff));
      end
      if (a_diff_r > 0) begin
        gain_sum_nxt = gain_sum_nxt + ISUM_W'(diff_mag(a_diff_r));
      end else begin
        loss_sum_nxt = loss_sum_nxt + ISUM_W'(diff_mag(a_diff_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_sum_r <= '0;
      loss_sum_r <= '0;
    end else if (restart) begin
      gain_sum_r <= '0;
      loss_sum_r <= '0;
    end else if (a_v && space_b) begin
      gain_sum_r <= gain_sum_nxt;
      loss_sum_r <= loss_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (space_b) begin
      b_price_r <= a_price_r;
      b_ready_r <= a_ready_r;
    end
  end

  // Stage C: cross-multiply index against both thresholds
  logic [ISUM_W:0]       sum_total;
  logic [PROD_S_W-1:0]   c_lhs_r;
  logic [PROD_S_W-1:0]   c_buy_rhs_r;
  logic [PROD_S_W-1:0]   c_sell_rhs_r;
  logic                  c_nonzero_r;
  logic                  c_ready_r;
  logic [PRICE_BITS-1:0] c_price_r;
  logic [ISUM_W-1:0]     c_gain_r;
  logic [ISUM_W-1:0]     c_loss_r;

  assign sum_total = (ISUM_W+1)'(gain_sum_r) + (ISUM_W+1)'(loss_sum_r);

  always_ff @(posedge clk) begin
    if (space_c) begin
      c_lhs_r      <= PROD_S_W'(gain_sum_r) * PROD_S_W'(SCALE_FACTOR);
      c_buy_rhs_r  <= PROD_S_W'(oversold_r) * PROD_S_W'(sum_total);
      c_sell_rhs_r <= PROD_S_W'(overbought_r) * PROD_S_W'(sum_total);
      c_nonzero_r  <= (sum_total != '0);
      c_ready_r    <= b_ready_r;
      c_price_r    <= b_price_r;
      c_gain_r     <= gain_sum_r;
      c_loss_r     <= loss_sum_r;
    end
  end

  // Stage D: compare
  logic                  d_buy_r;
  logic                  d_sell_r;
  logic                  d_ready_r;
  logic [PRICE_BITS-1:0] d_price_r;
  logic [ISUM_W-1:0]     d_gain_r;
  logic [ISUM_W-1:0]     d_loss_r;

  always_ff @(posedge clk) begin
    if (space_d) begin
      d_buy_r   <= c_ready_r && c_nonzero_r && (c_lhs_r < c_buy_rhs_r);
      d_sell_r  <= c_ready_r && c_nonzero_r && (c_lhs_r > c_sell_rhs_r);
      d_ready_r <= c_ready_r;
      d_price_r <= c_price_r;
      d_gain_r  <= c_gain_r;
      d_loss_r  <= c_loss_r;
    end
  end

  // Stage E: trade against the position limit, update position and cash
  logic signed [POS_W-1:0]   held_r;
  logic signed [POS_W-1:0]   held_nxt;
  logic signed [MONEY_W-1:0] cash_r;
  logic signed [MONEY_W-1:0] cash_nxt;
  logic signed [POS_W:0]     held_ext;
  logic signed [POS_W:0]     lim_pos;
  logic signed [POS_W:0]     lim_neg;
  logic signed [MSUM_W-1:0]  cash_ext;
  logic signed [MSUM_W-1:0]  price_ext;
  logic signed [MSUM_W-1:0]  cash_sum;
  action_t                   trade_act;
  action_t                   e_action_r;
  logic                      e_ready_r;
  logic [PRICE_BITS-1:0]     e_price_r;
  logic [ISUM_W-1:0]         e_gain_r;
  logic [ISUM_W-1:0]         e_loss_r;
  logic                      ld_e;

  assign ld_e = d_v && space_e;

  always_comb begin
    held_ext  = (POS_W+1)'(held_r);
    lim_pos   = signed'({1'b0, 1'b0, limit_r});
    lim_neg   = -lim_pos;
    cash_ext  = MSUM_W'(cash_r);
    price_ext = signed'(MSUM_W'(d_price_r));
    trade_act = ACT_NONE;
    held_nxt  = held_r;
    cash_sum  = cash_ext;
    priority if (d_buy_r && (held_ext < lim_pos)) begin
      trade_act = ACT_BUY;
      held_nxt  = held_r + POS_ONE;
      cash_sum  = cash_ext - price_ext;
    end else if (d_sell_r && (held_ext > lim_neg)) begin
      trade_act = ACT_SELL;
      held_nxt  = held_r - POS_ONE;
      cash_sum  = cash_ext + price_ext;
    end
    cash_nxt = sat_money(cash_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cash_r <= '0;
    end else if (ld_e) begin
      held_r <= held_nxt;
      cash_r <= cash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (space_e) begin
      e_action_r <= trade_act;
      e_ready_r  <= d_ready_r;
      e_price_r  <= d_price_r;
      e_gain_r   <= d_gain_r;
      e_loss_r   <= d_loss_r;
    end
  end

  // Stage F: value the holding at the current price
  logic signed [PROD_W-1:0]  f_prod_r;
  logic signed [MONEY_W-1:0] f_cash_r;
  logic signed [POS_W-1:0]   f_held_r;
  action_t                   f_action_r;
  logic                      f_ready_r;
  logic [ISUM_W-1:0]         f_gain_r;
  logic [ISUM_W-1:0]         f_loss_r;

  always_ff @(posedge clk) begin
    if (space_f) begin
      f_prod_r   <= PROD_W'(held_r) * signed'(PROD_W'(e_price_r));
      f_cash_r   <= cash_r;
      f_held_r   <= held_r;
      f_action_r <= e_action_r;
      f_ready_r  <= e_ready_r;
      f_gain_r   <= e_gain_r;
      f_loss_r   <= e_loss_r;
    end
  end

  // Stage G: output register with marked value
  action_t                   g_action_r;
  logic                      g_ready_r;
  logic [SUM_W-1:0]          g_gain_r;
  logic [SUM_W-1:0]          g_loss_r;
  logic signed [POS_W-1:0]   g_held_r;
  logic signed [MONEY_W-1:0] g_cash_r;
  logic signed [MONEY_W-1:0] g_marked_r;
  logic signed [MSUM_W-1:0]  marked_sum;

  assign marked_sum = MSUM_W'(f_cash_r) + MSUM_W'(f_prod_r);

  always_ff @(posedge clk) begin
    if (space_g) begin
      g_action_r <= f_action_r;
      g_ready_r  <= f_ready_r;
      g_gain_r   <= SUM_W'(f_gain_r);
      g_loss_r   <= SUM_W'(f_loss_r);
      g_held_r   <= f_held_r;
      g_cash_r   <= f_cash_r;
      g_marked_r <= sat_money(marked_sum);
    end
  end

  assign out_chan.valid        = g_v;
  assign out_chan.action       = g_action_r;
  assign out_chan.window_ready = g_ready_r;
  assign out_chan.gain_total   = g_gain_r;
  assign out_chan.loss_total   = g_loss_r;
  assign out_chan.position     = g_held_r;
  assign out_chan.cash_flow    = g_cash_r;
  assign out_chan.marked_value = g_marked_r;

`ifndef SYNTHESIS
  // Position never reaches the most negative code
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != {1'b1, {(POS_W-1){1'b0}}})
    else $error("position left the allowed range");

  // A window length write restarts the warm-up
  a_restart_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> !ring_stat.has_diff && !ring_stat.ready)
    else $error("warm-up not restarted after window length write");

  // A buy moves the position up by exactly one unit
  a_buy_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_e && trade_act == ACT_BUY) |=> (held_r == $past(held_r) + POS_ONE))
    else $error("buy did not add one unit");
`endif

endmodule
